// ----- src/soq_pkg.sv -----
// Shared types, constants and helper functions for the seat occupancy qualifier.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package soq_pkg;

  localparam int unsigned RunW    = 8;
  localparam int unsigned SampleW = 16;
  localparam int unsigned ScaledW = SampleW + 2;
  localparam int unsigned PaddrW  = 4;
  localparam int unsigned PdataW  = 32;

  // Band limits on the scaled sample (inclusive)
  localparam logic [ScaledW-1:0] OccLow    = ScaledW'(2000);
  localparam logic [ScaledW-1:0] OccHigh   = ScaledW'(10000);
  localparam logic [ScaledW-1:0] UnoccLow  = ScaledW'(12000);
  localparam logic [ScaledW-1:0] UnoccHigh = ScaledW'(20000);

  localparam logic [RunW-1:0] RunMax      = {RunW{1'b1}};
  localparam logic [RunW-1:0] ThreshReset = RunW'(10);

  // Register indexes, taken from paddr[3:2]
  localparam logic [1:0] RegOccThresh   = 2'd0;
  localparam logic [1:0] RegUnoccThresh = 2'd1;
  localparam logic [1:0] RegUnkThresh   = 2'd2;

  localparam logic ModeSample   = 1'b0;
  localparam logic ModeEvaluate = 1'b1;

  typedef enum logic [1:0] {
    ST_UNOCCUPIED = 2'd0,
    ST_OCCUPIED   = 2'd1,
    ST_UNKNOWN    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    BAND_UNOCC,
    BAND_OCC,
    BAND_UNDET,
    BAND_NONE
  } band_e;

  typedef struct packed {
    logic [RunW-1:0] occ;
    logic [RunW-1:0] unocc;
    logic [RunW-1:0] unk;
  } thresh_t;

  typedef struct packed {
    logic [RunW-1:0] occ;
    logic [RunW-1:0] unocc;
    logic [RunW-1:0] undet;
  } runs_t;

  function automatic band_e classify(input logic [SampleW-1:0] raw);
    logic [ScaledW-1:0] v;
    band_e              b;
    v = {raw, 2'b00};
    if (v >= UnoccLow && v <= UnoccHigh) begin
      b = BAND_UNOCC;
    end else if (v >= OccLow && v <= OccHigh) begin
      b = BAND_OCC;
    end else if (v < UnoccLow) begin
      b = BAND_UNDET;
    end else begin
      b = BAND_NONE;
    end
    return b;
  endfunction

  function automatic logic [RunW-1:0] bump(input logic [RunW-1:0] c);
    return (c == RunMax) ? c : c + RunW'(1);
  endfunction

endpackage

// ----- src/soq_regs.sv -----
// APB-style threshold register file for the seat occupancy qualifier.
// Depends on soq_pkg.
`timescale 1ns / 1ps

module soq_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [soq_pkg::PaddrW-1:0] paddr,
  input  logic [soq_pkg::PdataW-1:0] pwdata,
  output logic [soq_pkg::PdataW-1:0] prdata,
  output logic                       pready,
  output soq_pkg::thresh_t           thresh_o
);
  import soq_pkg::*;

  thresh_t    thresh_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q.occ   <= ThreshReset;
      thresh_q.unocc <= ThreshReset;
      thresh_q.unk   <= ThreshReset;
    end else if (wr_en) begin
      case (reg_idx)
        RegOccThresh:   thresh_q.occ   <= pwdata[RunW-1:0];
        RegUnoccThresh: thresh_q.unocc <= pwdata[RunW-1:0];
        RegUnkThresh:   thresh_q.unk   <= pwdata[RunW-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegOccThresh:   prdata = {{(PdataW-RunW){1'b0}}, thresh_q.occ};
      RegUnoccThresh: prdata = {{(PdataW-RunW){1'b0}}, thresh_q.unocc};
      RegUnkThresh:   prdata = {{(PdataW-RunW){1'b0}}, thresh_q.unk};
      default:        prdata = '0;
    endcase
  end

  assign thresh_o = thresh_q;

endmodule

// ----- src/soq_core.sv -----
// Run counters and status machine of the seat occupancy qualifier.
// Depends on soq_pkg; updates once per item presented with fire_i.
`timescale 1ns / 1ps

module soq_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  logic                        mode_i,
  input  logic [soq_pkg::SampleW-1:0] sample_i,
  input  soq_pkg::thresh_t            thresh_i,
  output logic [1:0]                  status_next_o
);
  import soq_pkg::*;

  logic [1:0] status_q, status_d;
  runs_t      runs_q, runs_d;
  band_e      band;
  logic       occ_met, unocc_met, und_met;

  assign band      = classify(sample_i);
  assign occ_met   = runs_q.occ   >= thresh_i.occ;
  assign unocc_met = runs_q.unocc >= thresh_i.unocc;
  assign und_met   = runs_q.undet >= thresh_i.unk;

  always_comb begin
    status_d = status_q;
    runs_d   = runs_q;
    if (mode_i == ModeSample) begin
      case (band)
        BAND_UNOCC: runs_d = '{occ: '0, unocc: bump(runs_q.unocc), undet: '0};
        BAND_OCC:   runs_d = '{occ: bump(runs_q.occ), unocc: '0, undet: '0};
        BAND_UNDET: runs_d = '{occ: '0, unocc: '0, undet: bump(runs_q.undet)};
        default:    ; // above the top band: drop the sample
      endcase
    end else begin
      case (status_q)
        ST_UNOCCUPIED: begin
          if (occ_met) begin
            status_d = ST_OCCUPIED;
            runs_d   = '0;
          end else if (und_met) begin
            status_d = ST_UNKNOWN;
            runs_d   = '0;
          end
        end
        ST_OCCUPIED: begin
          if (unocc_met) begin
            status_d = ST_UNOCCUPIED;
            runs_d   = '0;
          end else if (und_met) begin
            status_d = ST_UNKNOWN;
            runs_d   = '0;
          end
        end
        ST_UNKNOWN: begin
          if (occ_met) begin
            status_d = ST_OCCUPIED;
            runs_d   = '0;
          end else if (unocc_met) begin
            status_d = ST_UNOCCUPIED;
            runs_d   = '0;
          end
        end
        default: status_d = ST_UNKNOWN; // illegal code: recover, keep counters
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= ST_UNOCCUPIED;
      runs_q   <= '0;
    end else if (fire_i) begin
      status_q <= status_d;
      runs_q   <= runs_d;
    end
  end

  assign status_next_o = status_d;

endmodule

// ----- src/seat_occupancy_qualifier.sv -----
// Top level of the seat occupancy qualifier: input register, result register, handshakes.
// Depends on soq_pkg, soq_regs and soq_core.
//
//   channel | signals                                         | direction
//   in      | in_valid_i, in_stall_o, mode_i, sample_i        | item in
//   out     | out_valid_o, out_stall_i, seat_status_o         | result out
//   cfg     | psel, penable, pwrite, paddr, pwdata, prdata,   | thresholds
//           | pready                                          |
//
// Each item is held in the input register and then moves into the result register;
// one item is taken every cycle while in_stall_o is low. The run counters and status update
// as an item moves into the result register, so the next item sees them at once.
// Reset clears the valid flags, counters and status (unoccupied), thresholds to 10.
// A stall on the output holds the result register; in_stall_o rises only while both
// registers are full and the output is stalled.
`timescale 1ns / 1ps

module seat_occupancy_qualifier (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        mode_i,
  input  logic [soq_pkg::SampleW-1:0] sample_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  seat_status_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [soq_pkg::PaddrW-1:0]  paddr,
  input  logic [soq_pkg::PdataW-1:0]  pwdata,
  output logic [soq_pkg::PdataW-1:0]  prdata,
  output logic                        pready
);
  import soq_pkg::*;

  thresh_t            thresh;
  logic               in_valid_q;
  logic               mode_q;
  logic [SampleW-1:0] sample_q;
  logic               out_valid_q;
  logic [1:0]         status_q;
  logic [1:0]         status_next;
  logic               out_free;
  logic               fire;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  soq_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .thresh_o (thresh)
  );

  soq_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .mode_i        (mode_q),
    .sample_i      (sample_q),
    .thresh_i      (thresh),
    .status_next_o (status_next)
  );

  // Input register: take a transfer whenever it is not held
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      mode_q   <= mode_i;
      sample_q <= sample_i;
    end
  end

  // Result register: advance when free, hold under stall
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= status_next;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign seat_status_o = status_q;

endmodule

// ----- tb/soq_checker.sv -----
// Scoreboard for the seat occupancy qualifier: follows threshold writes on the APB port,
// predicts the status of every accepted item and compares it with the result stream.
// Depends on soq_pkg for widths, register indexes, mode codes and the status enum.
`timescale 1ns / 1ps

module soq_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic                        mode_i,
  input  logic [soq_pkg::SampleW-1:0] sample_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [1:0]                  seat_status_i,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [soq_pkg::PaddrW-1:0]  paddr_i,
  input  logic [soq_pkg::PdataW-1:0]  pwdata_i,
  input  logic                        pready_i,
  output int                          fail_count_o,
  output int                          pending_o
);
  import soq_pkg::*;

  // Band limits on the sample after scaling by four
  localparam int unsigned ScaledOccLo   = 2000;
  localparam int unsigned ScaledOccHi   = 10000;
  localparam int unsigned ScaledUnoccLo = 12000;
  localparam int unsigned ScaledUnoccHi = 20000;
  localparam logic [RunW-1:0] ThrAtReset = RunW'(10);
  localparam int MaxPrinted = 40;

  logic [RunW-1:0] occ_thr, unocc_thr, unk_thr;
  logic [RunW-1:0] occ_run, unocc_run, undet_run;
  status_e         seat_now;
  status_e         status_q[$];
  status_e         oldest_status;

  task automatic report_mismatch(input string what);
    fail_count_o++;
    if (fail_count_o <= MaxPrinted) $display("[%0t] soq_checker: %s", $time, what);
  endtask

  function automatic logic [RunW-1:0] sat_inc(input logic [RunW-1:0] c);
    return (c == {RunW{1'b1}}) ? c : c + 1'b1;
  endfunction

  task automatic take_sample(input logic [SampleW-1:0] raw);
    int unsigned v;
    v = int'(raw) * 4;
    if (v >= ScaledUnoccLo && v <= ScaledUnoccHi) begin
      unocc_run = sat_inc(unocc_run);
      occ_run   = '0;
      undet_run = '0;
    end else if (v >= ScaledOccLo && v <= ScaledOccHi) begin
      occ_run   = sat_inc(occ_run);
      unocc_run = '0;
      undet_run = '0;
    end else if (v < ScaledUnoccLo) begin
      undet_run = sat_inc(undet_run);
      occ_run   = '0;
      unocc_run = '0;
    end
    // above the unoccupied band: leave every counter alone
  endtask

  task automatic switch_to(input status_e next);
    occ_run   = '0;
    unocc_run = '0;
    undet_run = '0;
    seat_now  = next;
  endtask

  task automatic evaluate_seat();
    bit occ_hit, unocc_hit, undet_hit;
    occ_hit   = occ_run >= occ_thr;
    unocc_hit = unocc_run >= unocc_thr;
    undet_hit = undet_run >= unk_thr;
    case (seat_now)
      ST_UNOCCUPIED: begin
        if (occ_hit) switch_to(ST_OCCUPIED);
        else if (undet_hit) switch_to(ST_UNKNOWN);
      end
      ST_OCCUPIED: begin
        if (unocc_hit) switch_to(ST_UNOCCUPIED);
        else if (undet_hit) switch_to(ST_UNKNOWN);
      end
      ST_UNKNOWN: begin
        if (occ_hit) switch_to(ST_OCCUPIED);
        else if (unocc_hit) switch_to(ST_UNOCCUPIED);
      end
      default: seat_now = ST_UNKNOWN;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_thr   = ThrAtReset;
      unocc_thr = ThrAtReset;
      unk_thr   = ThrAtReset;
      occ_run   = '0;
      unocc_run = '0;
      undet_run = '0;
      seat_now  = ST_UNOCCUPIED;
      status_q.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[PaddrW-1:2])
          RegOccThresh:   occ_thr   = pwdata_i[RunW-1:0];
          RegUnoccThresh: unocc_thr = pwdata_i[RunW-1:0];
          RegUnkThresh:   unk_thr   = pwdata_i[RunW-1:0];
          default: ;
        endcase
      end
      // compare before the new prediction so a stray result is never matched to it
      if (out_valid_i && !out_stall_i) begin
        if (status_q.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing expected", seat_status_i));
        end else begin
          oldest_status = status_q.pop_front();
          if (seat_status_i !== oldest_status)
            report_mismatch($sformatf("seat_status %0d, expected %0d",
                                      seat_status_i, oldest_status));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (mode_i == ModeSample) take_sample(sample_i);
        else evaluate_seat();
        status_q.push_back(seat_now);
      end
      pending_o = status_q.size();
    end
  end

endmodule

// ----- tb/tb_seat_occupancy_qualifier.sv -----
// Testbench top for the seat occupancy qualifier: clock, reset, threshold writes and
// randomised sample/evaluate traffic with idle bursts on both sides.
// Depends on soq_pkg, seat_occupancy_qualifier and soq_checker.
`timescale 1ns / 1ps

module tb_seat_occupancy_qualifier;
  import soq_pkg::*;

  typedef enum int {ZoneOcc, ZoneUnocc, ZoneUndet, ZoneIgnored} zone_e;

  // Band limits in raw units (scaled limit divided by four)
  localparam int RawOccLo   = 500;
  localparam int RawOccHi   = 2500;
  localparam int RawUnoccLo = 3000;
  localparam int RawUnoccHi = 5000;
  localparam int RawMax     = 65535;
  localparam logic [1:0] RegSpare = 2'd3;
  localparam int HoldCycles = 40;
  localparam int SatRun     = 258;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid;
  logic               in_stall;
  logic               mode;
  logic [SampleW-1:0] sample;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         seat_status;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PaddrW-1:0]  paddr;
  logic [PdataW-1:0]  pwdata;
  logic [PdataW-1:0]  prdata;
  logic               pready;

  int fail_count;
  int pending;
  int sent_items;
  bit gaps_on;
  bit hold_req;

  seat_occupancy_qualifier u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .mode_i       (mode),
    .sample_i     (sample),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .seat_status_o(seat_status),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  soq_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .mode_i       (mode),
    .sample_i     (sample),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .seat_status_i(seat_status),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold-off on request
  initial begin
    bit held;
    out_stall = 1'b0;
    held      = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !held) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall <= 1'b0;
        held = 1'b1;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [SampleW-1:0] pick_raw(input zone_e z);
    logic [SampleW-1:0] r;
    case (z)
      ZoneOcc:   r = SampleW'($urandom_range(RawOccLo, RawOccHi));
      ZoneUnocc: r = SampleW'($urandom_range(RawUnoccLo, RawUnoccHi));
      ZoneUndet: begin
        if ($urandom_range(0, 1) == 0) r = SampleW'($urandom_range(0, RawOccLo - 1));
        else r = SampleW'($urandom_range(RawOccHi + 1, RawUnoccLo - 1));
      end
      default:   r = SampleW'($urandom_range(RawUnoccHi + 1, RawMax));
    endcase
    return r;
  endfunction

  // Called at a rising edge; returns at the edge of the transfer (or after a gap)
  task automatic send_item(input logic m, input logic [SampleW-1:0] s);
    bit taken;
    in_valid <= 1'b1;
    mode     <= m;
    sample   <= s;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall;
      @(posedge clk_i);
    end
    sent_items++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [RunW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {(PdataW - RunW)'($urandom), val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_thresholds(input logic [RunW-1:0] o, u, k);
    cfg_write(RegOccThresh, o);
    cfg_write(RegUnoccThresh, u);
    cfg_write(RegUnkThresh, k);
    @(posedge clk_i);
  endtask

  // One run of samples from a single band, with the odd stray item, then evaluate
  task automatic send_run(input int max_len);
    zone_e z;
    int    len;
    z   = zone_e'($urandom_range(0, 2));
    len = $urandom_range(1, max_len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) send_item(ModeSample, pick_raw(ZoneIgnored));
      else if ($urandom_range(0, 29) == 0) send_item(ModeEvaluate, SampleW'($urandom));
      else send_item(ModeSample, pick_raw(z));
    end
    repeat ($urandom_range(1, 2)) send_item(ModeEvaluate, SampleW'($urandom));
  endtask

  task automatic run_phase(input logic [RunW-1:0] o, u, k, input int n, input int max_len,
                           input bit idle, input bit hold);
    int stop;
    drain();
    set_thresholds(o, u, k);
    gaps_on  = idle;
    hold_req = hold;
    stop = sent_items + n;
    while (sent_items < stop) send_run(max_len);
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    mode       = ModeSample;
    sample     = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    sent_items = 0;
    gaps_on    = 1'b1;
    hold_req   = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Band edges at reset thresholds, ignored samples included
    send_item(ModeSample, SampleW'(0));
    send_item(ModeSample, SampleW'(RawOccLo - 1));
    send_item(ModeSample, SampleW'(RawOccLo));
    send_item(ModeSample, SampleW'(RawOccHi));
    send_item(ModeSample, SampleW'(RawOccHi + 1));
    send_item(ModeSample, SampleW'(RawUnoccLo - 1));
    send_item(ModeSample, SampleW'(RawUnoccLo));
    send_item(ModeSample, SampleW'(RawUnoccHi));
    send_item(ModeSample, SampleW'(RawUnoccHi + 1));
    send_item(ModeSample, SampleW'(RawMax));
    send_item(ModeEvaluate, SampleW'(RawMax));

    // Zero thresholds switch on every evaluate; the spare address must change nothing
    drain();
    set_thresholds('0, '0, '0);
    cfg_write(RegSpare, '1);
    send_item(ModeEvaluate, '0);
    send_item(ModeEvaluate, SampleW'(RawMax));
    drain();
    set_thresholds('1, '1, '0);
    send_item(ModeEvaluate, '0);
    send_item(ModeEvaluate, '0);
    send_item(ModeSample, SampleW'(RawOccLo));
    send_item(ModeEvaluate, '0);

    run_phase(8'd10, 8'd10, 8'd10, 20, 14, 1'b1, 1'b1);
    run_phase('0, '0, '0, 15, 3, 1'b1, 1'b0);
    run_phase(8'd1, 8'd2, 8'd3, 15, 6, 1'b1, 1'b0);
    run_phase(RunW'($urandom_range(0, 24)), RunW'($urandom_range(0, 24)),
              RunW'($urandom_range(0, 24)), 20, 28, 1'b1, 1'b0);

    // Saturate each counter in turn: occupied, then unknown, then unoccupied
    drain();
    set_thresholds('1, '1, '1);
    repeat (SatRun) send_item(ModeSample, pick_raw(ZoneOcc));
    send_item(ModeEvaluate, '0);
    repeat (SatRun) send_item(ModeSample, pick_raw(ZoneUndet));
    send_item(ModeEvaluate, '0);
    repeat (SatRun) send_item(ModeSample, pick_raw(ZoneUnocc));
    send_item(ModeEvaluate, '0);

    run_phase('1, '0, RunW'($urandom_range(0, 8)), 10, 10, 1'b1, 1'b0);
    run_phase(RunW'($urandom_range(0, 12)), RunW'($urandom_range(0, 12)),
              RunW'($urandom_range(0, 12)), 20, 16, 1'b0, 1'b0);

    drain();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
